FILE: sv/nsdof_pkg.sv
package nsdof_pkg;

  // Fixed-point format of every value
  localparam int DATA_WIDTH = 48;
  localparam int FRAC_BITS  = 24;
  localparam int MAG_WIDTH  = DATA_WIDTH - 1;

  // Accumulator holds the exact sum of up to four values
  localparam int ACC_WIDTH  = DATA_WIDTH + 2;

  // Multiplier splits each magnitude into two halves
  localparam int HALF_W     = (DATA_WIDTH + 1) / 2;
  localparam int MAGP_W     = 2 * HALF_W;
  localparam int PROD_W     = 4 * HALF_W;

  // Configuration port
  localparam int CFG_DW     = 64;
  localparam int CFG_AW     = 6;
  localparam int CFG_SEL_LO = 3;
  localparam int REG_IDX_W  = 3;

  // Sequencer program
  localparam int NUM_STEPS  = 18;
  localparam int STEP_W     = 5;

  localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [MAG_WIDTH-1:0]         MAG_MAX = {MAG_WIDTH{1'b1}};

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] ground_accel;
    logic                         last_sample;
  } in_item_t;

  typedef struct packed {
    logic [MAG_WIDTH-1:0] peak_accel;
    logic [MAG_WIDTH-1:0] peak_vel;
    logic [MAG_WIDTH-1:0] peak_disp;
  } out_item_t;

  // Register indexes, also used as multiplier coefficient selects
  typedef enum logic [REG_IDX_W-1:0] {
    REG_INV_EFF_K  = 3'd0,
    REG_LOAD_DISP  = 3'd1,
    REG_LOAD_VEL   = 3'd2,
    REG_LOAD_ACC   = 3'd3,
    REG_ACC_DU     = 3'd4,
    REG_VEL_DU     = 3'd5,
    REG_ACC_V      = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    MB_DISP  = 2'd0,
    MB_VEL   = 2'd1,
    MB_ACCEL = 2'd2,
    MB_TMP   = 2'd3
  } mul_b_e;

  typedef enum logic [2:0] {
    ACC_NOP = 3'd0,
    ACC_LD  = 3'd1,
    ACC_LDN = 3'd2,
    ACC_ADD = 3'd3,
    ACC_SUB = 3'd4
  } acc_op_e;

  typedef enum logic [2:0] {
    SRC_G     = 3'd0,
    SRC_PROD  = 3'd1,
    SRC_DISP  = 3'd2,
    SRC_VEL   = 3'd3,
    SRC_ACCEL = 3'd4
  } acc_src_e;

  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_TMP    = 3'd1,
    WR_UNEW   = 3'd2,
    WR_VNEW   = 3'd3,
    WR_COMMIT = 3'd4,
    WR_PEAK   = 3'd5
  } wr_e;

  typedef enum logic [1:0] {
    SEQ_NEXT     = 2'd0,
    SEQ_WAIT_MUL = 2'd1,
    SEQ_WAIT_OUT = 2'd2
  } seq_e;

  typedef struct packed {
    seq_e     seq;
    logic     mul_start;
    reg_idx_e mul_a;
    mul_b_e   mul_b;
    acc_op_e  acc_op;
    acc_src_e acc_src;
    wr_e      wr;
  } ctrl_word_t;

  typedef struct packed {
    logic                         start;
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                         busy;
    logic                         done;
    logic signed [DATA_WIDTH-1:0] prod;
  } mul_rsp_t;

  // Build one control word
  function automatic ctrl_word_t cw(seq_e seq, logic start, reg_idx_e ma, mul_b_e mb,
                                    acc_op_e op, acc_src_e src, wr_e wr);
    ctrl_word_t c;
    c.seq       = seq;
    c.mul_start = start;
    c.mul_a     = ma;
    c.mul_b     = mb;
    c.acc_op    = op;
    c.acc_src   = src;
    c.wr        = wr;
    return c;
  endfunction

  // Program for one integration step
  function automatic ctrl_word_t ucode(logic [STEP_W-1:0] step);
    ctrl_word_t c;
    c = cw(SEQ_WAIT_OUT, 1'b0, REG_INV_EFF_K, MB_TMP, ACC_NOP, SRC_G, WR_NONE);
    case (step)
      // effective load: -g + a1*u + a2*v + a3*a
      5'd0:  c = cw(SEQ_NEXT, 1'b1, REG_LOAD_DISP, MB_DISP, ACC_LDN, SRC_G, WR_NONE);
      5'd1:  c = cw(SEQ_WAIT_MUL, 1'b1, REG_LOAD_VEL, MB_VEL, ACC_ADD, SRC_PROD, WR_NONE);
      5'd2:  c = cw(SEQ_WAIT_MUL, 1'b1, REG_LOAD_ACC, MB_ACCEL, ACC_ADD, SRC_PROD, WR_NONE);
      5'd3:  c = cw(SEQ_WAIT_MUL, 1'b0, REG_LOAD_ACC, MB_ACCEL, ACC_ADD, SRC_PROD, WR_NONE);
      5'd4:  c = cw(SEQ_NEXT, 1'b0, REG_INV_EFF_K, MB_TMP, ACC_NOP, SRC_G, WR_TMP);
      // new displacement and its change
      5'd5:  c = cw(SEQ_NEXT, 1'b1, REG_INV_EFF_K, MB_TMP, ACC_NOP, SRC_G, WR_NONE);
      5'd6:  c = cw(SEQ_WAIT_MUL, 1'b0, REG_INV_EFF_K, MB_TMP, ACC_LD, SRC_PROD, WR_UNEW);
      5'd7:  c = cw(SEQ_NEXT, 1'b0, REG_INV_EFF_K, MB_TMP, ACC_SUB, SRC_DISP, WR_NONE);
      5'd8:  c = cw(SEQ_NEXT, 1'b0, REG_INV_EFF_K, MB_TMP, ACC_NOP, SRC_G, WR_TMP);
      // new velocity
      5'd9:  c = cw(SEQ_NEXT, 1'b1, REG_VEL_DU, MB_TMP, ACC_NOP, SRC_G, WR_NONE);
      5'd10: c = cw(SEQ_WAIT_MUL, 1'b1, REG_ACC_DU, MB_TMP, ACC_LD, SRC_PROD, WR_NONE);
      5'd11: c = cw(SEQ_NEXT, 1'b0, REG_ACC_DU, MB_TMP, ACC_SUB, SRC_VEL, WR_NONE);
      5'd12: c = cw(SEQ_NEXT, 1'b0, REG_ACC_DU, MB_TMP, ACC_NOP, SRC_G, WR_VNEW);
      // new acceleration
      5'd13: c = cw(SEQ_WAIT_MUL, 1'b1, REG_ACC_V, MB_VEL, ACC_LD, SRC_PROD, WR_NONE);
      5'd14: c = cw(SEQ_WAIT_MUL, 1'b0, REG_ACC_V, MB_VEL, ACC_SUB, SRC_PROD, WR_NONE);
      5'd15: c = cw(SEQ_NEXT, 1'b0, REG_ACC_V, MB_VEL, ACC_SUB, SRC_ACCEL, WR_NONE);
      5'd16: c = cw(SEQ_NEXT, 1'b0, REG_ACC_V, MB_VEL, ACC_NOP, SRC_G, WR_COMMIT);
      // peaks, result on the last sample
      5'd17: c = cw(SEQ_WAIT_OUT, 1'b0, REG_ACC_V, MB_VEL, ACC_NOP, SRC_G, WR_PEAK);
      default: c = cw(SEQ_WAIT_OUT, 1'b0, REG_INV_EFF_K, MB_TMP, ACC_NOP, SRC_G, WR_NONE);
    endcase
    return c;
  endfunction

  // Saturate an exact sum to the value range
  function automatic logic signed [DATA_WIDTH-1:0] sat_acc(logic signed [ACC_WIDTH-1:0] x);
    logic [ACC_WIDTH-DATA_WIDTH:0] top;
    top = x[ACC_WIDTH-1:DATA_WIDTH-1];
    if ((&top) || !(|top)) begin
      return x[DATA_WIDTH-1:0];
    end
    return x[ACC_WIDTH-1] ? SAT_MIN : SAT_MAX;
  endfunction

  // Saturating magnitude
  function automatic logic [MAG_WIDTH-1:0] mag(logic signed [DATA_WIDTH-1:0] x);
    logic [DATA_WIDTH-1:0] n;
    n = ~x + 1'b1;
    if (!x[DATA_WIDTH-1]) begin
      return x[MAG_WIDTH-1:0];
    end
    if (x == SAT_MIN) begin
      return MAG_MAX;
    end
    return n[MAG_WIDTH-1:0];
  endfunction

endpackage

FILE: sv/nsdof_mul.sv
module nsdof_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nsdof_pkg::mul_req_t req_i,
  output nsdof_pkg::mul_rsp_t rsp_o
);
  import nsdof_pkg::*;

  logic [MAGP_W-1:0]   amag_q, bmag_q;
  logic                neg_q;
  logic [PROD_W-1:0]   sum_q;
  logic [1:0]          cnt_q;
  logic                run_q, fin_q, done_q;
  logic signed [DATA_WIDTH-1:0] prod_q;

  logic [DATA_WIDTH-1:0] amag, bmag;
  logic [HALF_W-1:0]     ah, bh;
  logic [2*HALF_W-1:0]   pp;
  logic [1:0]            sh;
  logic [PROD_W-1:0]     pp_ext;
  logic signed [PROD_W:0] s_full, s_sh;
  logic [PROD_W-DATA_WIDTH+1:0] s_top;
  logic signed [DATA_WIDTH-1:0] s_sat;

  // Operand magnitudes
  assign amag = req_i.a[DATA_WIDTH-1] ? (~req_i.a + 1'b1) : req_i.a;
  assign bmag = req_i.b[DATA_WIDTH-1] ? (~req_i.b + 1'b1) : req_i.b;

  // One half-by-half partial product per cycle
  assign ah     = cnt_q[1] ? amag_q[MAGP_W-1:HALF_W] : amag_q[HALF_W-1:0];
  assign bh     = cnt_q[0] ? bmag_q[MAGP_W-1:HALF_W] : bmag_q[HALF_W-1:0];
  assign pp     = ah * bh;
  assign sh     = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
  assign pp_ext = PROD_W'(pp) << (HALF_W * sh);

  // Apply sign, floor shift, saturate
  assign s_full = neg_q ? -$signed({1'b0, sum_q}) : $signed({1'b0, sum_q});
  assign s_sh   = s_full >>> FRAC_BITS;
  assign s_top  = s_sh[PROD_W:DATA_WIDTH-1];
  assign s_sat  = ((&s_top) || !(|s_top)) ? s_sh[DATA_WIDTH-1:0]
                                          : (s_sh[PROD_W] ? SAT_MIN : SAT_MAX);

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        run_q <= 1'b0;
        fin_q <= 1'b1;
      end
    end else if (fin_q) begin
      fin_q  <= 1'b0;
      done_q <= 1'b1;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      amag_q <= MAGP_W'(amag);
      bmag_q <= MAGP_W'(bmag);
      neg_q  <= req_i.a[DATA_WIDTH-1] ^ req_i.b[DATA_WIDTH-1];
      sum_q  <= '0;
    end else if (run_q) begin
      sum_q <= sum_q + pp_ext;
    end else if (fin_q) begin
      prod_q <= s_sat;
    end
  end

  assign rsp_o.busy = run_q | fin_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

endmodule

FILE: sv/newmark_sdof_peak_response_unit.sv
// Peak response of a damped unit-mass oscillator under ground shaking.
// Input channel (in_valid_i / in_stall_o / in_item_i) takes one ground
// acceleration sample per item; last_sample marks the end of a record.
// Output channel (out_valid_o / out_stall_i / out_item_o) carries one item
// per record: the peak magnitudes of relative acceleration, velocity and
// displacement, including the last sample.
// Seven coefficient registers sit on the APB-style port at 8*index; write
// them only while the block is idle.
// Each item runs an 18-step microprogram over one shared multiplier. A
// 48x48 product takes four passes through a 24x24 multiplier plus a
// rounding pass, and seven products chain per sample; the next item is
// accepted only once the previous one has finished its program.
// The result waits in an output register; a stalled receiver does not hold
// up the next record, except that the final step of a later record waits
// while that register is still full.
// Reset clears the coefficients, the oscillator state and the peaks.
module newmark_sdof_peak_response_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  nsdof_pkg::in_item_t                  in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output nsdof_pkg::out_item_t                 out_item_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [nsdof_pkg::CFG_AW-1:0]         paddr,
  input  logic [nsdof_pkg::CFG_DW-1:0]         pwdata,
  output logic [nsdof_pkg::CFG_DW-1:0]         prdata,
  output logic                                 pready
);
  import nsdof_pkg::*;

  // Coefficients
  logic signed [DATA_WIDTH-1:0] inv_eff_k_q, load_disp_q, load_vel_q, load_acc_q;
  logic signed [DATA_WIDTH-1:0] acc_du_q, vel_du_q, acc_v_q;

  // Oscillator state and peaks
  logic signed [DATA_WIDTH-1:0] disp_q, vel_q, accel_q;
  logic [MAG_WIDTH-1:0]         max_disp_q, max_vel_q, max_accel_q;

  // Working registers
  logic signed [DATA_WIDTH-1:0] g_q, tmp_q, unew_q, vnew_q;
  logic                         last_q;
  logic signed [ACC_WIDTH-1:0]  acc_q, acc_d, src;

  // Sequencer
  logic                         busy_q;
  logic [STEP_W-1:0]            step_q;
  ctrl_word_t                   ctrl;
  logic                         hold, exec;

  // Output register
  logic                         out_valid_q;
  out_item_t                    out_item_q;

  mul_req_t                     mul_req;
  mul_rsp_t                     mul_rsp;

  logic                         cfg_wr;
  reg_idx_e                     cfg_idx;
  logic signed [DATA_WIDTH-1:0] cfg_rd;
  logic [MAG_WIDTH-1:0]         nmax_disp, nmax_vel, nmax_accel;
  logic [MAG_WIDTH-1:0]         m_disp, m_vel, m_accel;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[CFG_AW-1:CFG_SEL_LO]);

  always_comb begin
    unique case (cfg_idx)
      REG_INV_EFF_K: cfg_rd = inv_eff_k_q;
      REG_LOAD_DISP: cfg_rd = load_disp_q;
      REG_LOAD_VEL:  cfg_rd = load_vel_q;
      REG_LOAD_ACC:  cfg_rd = load_acc_q;
      REG_ACC_DU:    cfg_rd = acc_du_q;
      REG_VEL_DU:    cfg_rd = vel_du_q;
      REG_ACC_V:     cfg_rd = acc_v_q;
      default:       cfg_rd = '0;
    endcase
  end
  assign prdata = CFG_DW'(cfg_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_eff_k_q <= '0;
      load_disp_q <= '0;
      load_vel_q  <= '0;
      load_acc_q  <= '0;
      acc_du_q    <= '0;
      vel_du_q    <= '0;
      acc_v_q     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_INV_EFF_K: inv_eff_k_q <= pwdata[DATA_WIDTH-1:0];
        REG_LOAD_DISP: load_disp_q <= pwdata[DATA_WIDTH-1:0];
        REG_LOAD_VEL:  load_vel_q  <= pwdata[DATA_WIDTH-1:0];
        REG_LOAD_ACC:  load_acc_q  <= pwdata[DATA_WIDTH-1:0];
        REG_ACC_DU:    acc_du_q    <= pwdata[DATA_WIDTH-1:0];
        REG_VEL_DU:    vel_du_q    <= pwdata[DATA_WIDTH-1:0];
        REG_ACC_V:     acc_v_q     <= pwdata[DATA_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Control word and stall conditions
  assign ctrl = ucode(step_q);
  assign hold = ((ctrl.seq == SEQ_WAIT_MUL) && !mul_rsp.done) ||
                ((ctrl.seq == SEQ_WAIT_OUT) && last_q && out_valid_q && out_stall_i);
  assign exec = busy_q && !hold;

  assign in_stall_o = busy_q;

  // Shared multiplier
  always_comb begin
    mul_req.start = exec && ctrl.mul_start;
    case (ctrl.mul_a)
      REG_INV_EFF_K: mul_req.a = inv_eff_k_q;
      REG_LOAD_DISP: mul_req.a = load_disp_q;
      REG_LOAD_VEL:  mul_req.a = load_vel_q;
      REG_LOAD_ACC:  mul_req.a = load_acc_q;
      REG_ACC_DU:    mul_req.a = acc_du_q;
      REG_VEL_DU:    mul_req.a = vel_du_q;
      REG_ACC_V:     mul_req.a = acc_v_q;
      default:       mul_req.a = '0;
    endcase
    case (ctrl.mul_b)
      MB_DISP:  mul_req.b = disp_q;
      MB_VEL:   mul_req.b = vel_q;
      MB_ACCEL: mul_req.b = accel_q;
      default:  mul_req.b = tmp_q;
    endcase
  end

  nsdof_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  // Accumulator
  always_comb begin
    case (ctrl.acc_src)
      SRC_G:     src = ACC_WIDTH'(g_q);
      SRC_PROD:  src = ACC_WIDTH'(mul_rsp.prod);
      SRC_DISP:  src = ACC_WIDTH'(disp_q);
      SRC_VEL:   src = ACC_WIDTH'(vel_q);
      default:   src = ACC_WIDTH'(accel_q);
    endcase
    case (ctrl.acc_op)
      ACC_LD:  acc_d = src;
      ACC_LDN: acc_d = -src;
      ACC_ADD: acc_d = acc_q + src;
      ACC_SUB: acc_d = acc_q - src;
      default: acc_d = acc_q;
    endcase
  end

  // Candidate peaks from the committed state
  assign m_disp     = mag(disp_q);
  assign m_vel      = mag(vel_q);
  assign m_accel    = mag(accel_q);
  assign nmax_disp  = (m_disp  > max_disp_q)  ? m_disp  : max_disp_q;
  assign nmax_vel   = (m_vel   > max_vel_q)   ? m_vel   : max_vel_q;
  assign nmax_accel = (m_accel > max_accel_q) ? m_accel : max_accel_q;

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (!busy_q) begin
      if (in_valid_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end
    end else if (exec) begin
      if (ctrl.seq == SEQ_WAIT_OUT) begin
        busy_q <= 1'b0;
        step_q <= '0;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // Capture the item, run the datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      g_q    <= in_item_i.ground_accel;
      last_q <= in_item_i.last_sample;
    end
    if (exec) begin
      acc_q <= acc_d;
      case (ctrl.wr)
        WR_TMP:  tmp_q  <= sat_acc(acc_q);
        WR_UNEW: unew_q <= mul_rsp.prod;
        WR_VNEW: vnew_q <= sat_acc(acc_q);
        default: ;
      endcase
    end
  end

  // Oscillator state and peaks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_q      <= '0;
      vel_q       <= '0;
      accel_q     <= '0;
      max_disp_q  <= '0;
      max_vel_q   <= '0;
      max_accel_q <= '0;
    end else if (exec && (ctrl.wr == WR_COMMIT)) begin
      disp_q  <= unew_q;
      vel_q   <= vnew_q;
      accel_q <= sat_acc(acc_q);
    end else if (exec && (ctrl.wr == WR_PEAK)) begin
      if (last_q) begin
        disp_q      <= '0;
        vel_q       <= '0;
        accel_q     <= '0;
        max_disp_q  <= '0;
        max_vel_q   <= '0;
        max_accel_q <= '0;
      end else begin
        max_disp_q  <= nmax_disp;
        max_vel_q   <= nmax_vel;
        max_accel_q <= nmax_accel;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec && (ctrl.wr == WR_PEAK) && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && (ctrl.wr == WR_PEAK) && last_q) begin
      out_item_q.peak_accel <= nmax_accel;
      out_item_q.peak_vel   <= nmax_vel;
      out_item_q.peak_disp  <= nmax_disp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A new product never starts over one still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier restarted while busy");

  // The step counter stays inside the program
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q < STEP_W'(NUM_STEPS)))
    else $error("step counter ran past the program");

  // A result only comes from the peak step of a last sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(exec && (ctrl.wr == WR_PEAK) && last_q))
    else $error("result raised outside the peak step");

  // The oscillator is back at rest after a record ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($fell(busy_q) && last_q) |->
      (disp_q == '0 && vel_q == '0 && accel_q == '0 && max_disp_q == '0))
    else $error("state not cleared after last sample");

  // The finished result holds while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_item_q)))
    else $error("stalled result changed");

endmodule
